// ===== rtl/ncs_pkg.sv =====
`default_nettype none

package ncs_pkg;

  localparam int unsigned NEST_BITS_DEF = 8;
  localparam int unsigned LINE_BITS_DEF = 16;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LINE_NUM_W = 16;

  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;

  function automatic logic is_white(input logic [BYTE_W-1:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) ||
           (b == CH_VT) || (b == CH_CR);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/nested_comment_stripper.sv =====
`default_nettype none
// Result words are registered: each is written into the result queue when its input word is accepted.
// Throughput: one input word per cycle while the receiver takes every result and each word
// yields at most one result; a word yielding two (flushed slash plus its own result) queues both.
// The four-entry result queue takes an input word whenever two entries are free.
// Reset (rst, synchronous): text mode, depth 0, no held slash, line 1, queue empty.
// An end-of-stream word also returns all scan state to these values.

module nested_comment_stripper #(
  parameter int unsigned NEST_BITS = ncs_pkg::NEST_BITS_DEF,
  parameter int unsigned LINE_BITS = ncs_pkg::LINE_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [ncs_pkg::BYTE_W-1:0]     in_byte,
  input  wire logic                           end_of_stream,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [ncs_pkg::BYTE_W-1:0]     out_byte,
  output logic                                byte_valid,
  output logic                                end_marker,
  output logic                                unclosed_error,
  output logic      [ncs_pkg::LINE_NUM_W-1:0] line_number,
  output logic                                last_of_run
);
  import ncs_pkg::*;

  localparam int unsigned EXT_W = (LINE_BITS > LINE_NUM_W) ? LINE_BITS : LINE_NUM_W;

  typedef enum logic [1:0] {
    MODE_TEXT  = 2'd0,
    MODE_LINE  = 2'd1,
    MODE_BLOCK = 2'd2
  } mode_t;

  typedef struct packed {
    logic [BYTE_W-1:0]     ch;
    logic                  bvalid;
    logic                  endm;
    logic                  err;
    logic [LINE_NUM_W-1:0] line;
    logic                  last;
  } entry_t;

  mode_t                scan_mode, scan_mode_next;
  logic [NEST_BITS-1:0] nest_depth, nest_depth_next;
  logic                 prev_was_slash, prev_was_slash_next;
  logic                 prev_was_star, prev_was_star_next;
  logic                 space_emitted, space_emitted_next;
  logic [LINE_BITS-1:0] line_count, line_count_next;

  entry_t               queue [4];
  logic [1:0]           wr_ptr, rd_ptr;
  logic [2:0]           count;

  logic                 accept, pop;
  logic                 pre_slash, main_push, main_end, main_err;
  logic [BYTE_W-1:0]    main_ch;
  logic                 bump, sp_eff;
  logic [NEST_BITS-1:0] depth_dec;
  logic [1:0]           n_res;
  logic [EXT_W-1:0]     line_ext;
  logic [LINE_NUM_W-1:0] line_sat;
  entry_t               res0, res1;

  assign accept = in_valid && in_ready;
  assign pop    = out_valid && out_ready;
  assign in_ready  = (count <= 3'd2);
  assign out_valid = (count != 3'd0);

  always_comb begin
    scan_mode_next      = scan_mode;
    nest_depth_next     = nest_depth;
    prev_was_slash_next = prev_was_slash;
    prev_was_star_next  = prev_was_star;
    space_emitted_next  = space_emitted;
    pre_slash = 1'b0;
    main_push = 1'b0;
    main_end  = 1'b0;
    main_err  = 1'b0;
    main_ch   = '0;
    bump      = 1'b0;
    sp_eff    = space_emitted;
    depth_dec = (nest_depth != '0) ? nest_depth - 1'b1 : nest_depth;

    if (end_of_stream) begin
      pre_slash = (scan_mode != MODE_LINE) && (scan_mode != MODE_BLOCK) && prev_was_slash;
      main_push = 1'b1;
      main_end  = 1'b1;
      main_err  = (scan_mode == MODE_BLOCK);
    end else begin
      unique case (scan_mode)
        MODE_LINE: begin
          if (in_byte == CH_LF) begin
            bump           = 1'b1;
            scan_mode_next = MODE_TEXT;
          end
        end
        MODE_BLOCK: begin
          bump = (in_byte == CH_LF);
          prev_was_slash_next = (in_byte == CH_SLASH);
          prev_was_star_next  = (in_byte == CH_STAR);
          if (prev_was_slash && in_byte == CH_STAR) begin
            if (nest_depth != '1) nest_depth_next = nest_depth + 1'b1;
          end else if (prev_was_star && in_byte == CH_SLASH) begin
            nest_depth_next = depth_dec;
            if (depth_dec == '0) begin
              scan_mode_next      = MODE_TEXT;
              prev_was_slash_next = 1'b0;
              prev_was_star_next  = 1'b0;
            end
          end
        end
        default: begin
          if (prev_was_slash && (in_byte == CH_SLASH || in_byte == CH_STAR)) begin
            // open a comment: at most one space for the whole comment
            prev_was_slash_next = 1'b0;
            if (in_byte == CH_SLASH) begin
              scan_mode_next = MODE_LINE;
            end else begin
              scan_mode_next     = MODE_BLOCK;
              nest_depth_next    = NEST_BITS'(1);
              prev_was_star_next = 1'b0;
            end
            if (!space_emitted) begin
              main_push          = 1'b1;
              main_ch            = CH_SPACE;
              space_emitted_next = 1'b1;
            end
          end else begin
            if (prev_was_slash) begin
              // release the held slash ahead of this byte
              pre_slash           = 1'b1;
              sp_eff              = 1'b0;
              space_emitted_next  = 1'b0;
              prev_was_slash_next = 1'b0;
            end
            if (is_white(in_byte)) begin
              bump = (in_byte == CH_LF);
              if (!sp_eff) begin
                main_push          = 1'b1;
                main_ch            = CH_SPACE;
                space_emitted_next = 1'b1;
              end
            end else if (in_byte == CH_SLASH) begin
              prev_was_slash_next = 1'b1;
            end else begin
              main_push          = 1'b1;
              main_ch            = in_byte;
              space_emitted_next = 1'b0;
            end
          end
        end
      endcase
    end

    line_count_next = (bump && line_count != '1) ? line_count + 1'b1 : line_count;
  end

  always_comb begin
    line_ext = EXT_W'(line_count_next);
    line_sat = (line_ext > EXT_W'({LINE_NUM_W{1'b1}})) ? {LINE_NUM_W{1'b1}}
                                                        : line_ext[LINE_NUM_W-1:0];
    n_res = {1'b0, pre_slash} + {1'b0, main_push};

    res1.ch     = main_ch;
    res1.bvalid = !main_end;
    res1.endm   = main_end;
    res1.err    = main_err;
    res1.line   = line_sat;
    res1.last   = 1'b1;

    res0.ch     = CH_SLASH;
    res0.bvalid = 1'b1;
    res0.endm   = 1'b0;
    res0.err    = 1'b0;
    res0.line   = line_sat;
    res0.last   = !main_push;
    if (!pre_slash) res0 = res1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode      <= MODE_TEXT;
      nest_depth     <= '0;
      prev_was_slash <= 1'b0;
      prev_was_star  <= 1'b0;
      space_emitted  <= 1'b0;
      line_count     <= {{(LINE_BITS-1){1'b0}}, 1'b1};
      wr_ptr         <= '0;
      rd_ptr         <= '0;
      count          <= '0;
    end else begin
      if (accept) begin
        if (end_of_stream) begin
          // end of stream: back to the reset state for the next stream
          scan_mode      <= MODE_TEXT;
          nest_depth     <= '0;
          prev_was_slash <= 1'b0;
          prev_was_star  <= 1'b0;
          space_emitted  <= 1'b0;
          line_count     <= {{(LINE_BITS-1){1'b0}}, 1'b1};
        end else begin
          scan_mode      <= scan_mode_next;
          nest_depth     <= nest_depth_next;
          prev_was_slash <= prev_was_slash_next;
          prev_was_star  <= prev_was_star_next;
          space_emitted  <= space_emitted_next;
          line_count     <= line_count_next;
        end
        wr_ptr <= wr_ptr + n_res;
      end
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + (accept ? {1'b0, n_res} : 3'd0) - {2'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (accept && n_res != 2'd0) queue[wr_ptr] <= res0;
    if (accept && n_res == 2'd2) queue[wr_ptr + 2'd1] <= res1;
  end

  assign out_byte       = queue[rd_ptr].ch;
  assign byte_valid     = queue[rd_ptr].bvalid;
  assign end_marker     = queue[rd_ptr].endm;
  assign unclosed_error = queue[rd_ptr].err;
  assign line_number    = queue[rd_ptr].line;
  assign last_of_run    = queue[rd_ptr].last;

endmodule

`default_nettype wire

// ===== rtl/ncs_checker.sv =====
`default_nettype none

module ncs_assertions (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [ncs_pkg::BYTE_W-1:0]     out_byte,
  input wire logic                           byte_valid,
  input wire logic                           end_marker,
  input wire logic                           unclosed_error,
  input wire logic [ncs_pkg::LINE_NUM_W-1:0] line_number,
  input wire logic                           last_of_run
);
  import ncs_pkg::*;

  // a word without a character is only ever the end-of-stream word
  a_novalid_is_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> end_marker)
    else $error("result without character is not an end marker");

  a_err_on_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && unclosed_error |-> end_marker && !byte_valid)
    else $error("unclosed error outside end word");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_marker |-> last_of_run)
    else $error("end word not marked last of run");

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> line_number != '0)
    else $error("line number is zero");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_of_run))
    else $error("stalled result word changed");

endmodule

bind nested_comment_stripper ncs_assertions u_ncs_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_byte       (out_byte),
  .byte_valid     (byte_valid),
  .end_marker     (end_marker),
  .unclosed_error (unclosed_error),
  .line_number    (line_number),
  .last_of_run    (last_of_run)
);

`default_nettype wire

// ===== sim/ncs_checker.sv =====
`default_nettype none

module ncs_checker (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  input  wire logic                           in_ready,
  input  wire logic [ncs_pkg::BYTE_W-1:0]     in_byte,
  input  wire logic                           end_of_stream,
  input  wire logic                           out_valid,
  input  wire logic                           out_ready,
  input  wire logic [ncs_pkg::BYTE_W-1:0]     out_byte,
  input  wire logic                           byte_valid,
  input  wire logic                           end_marker,
  input  wire logic                           unclosed_error,
  input  wire logic [ncs_pkg::LINE_NUM_W-1:0] line_number,
  input  wire logic                           last_of_run,
  output int                                  errors,
  output int                                  pending
);
  import ncs_pkg::*;

  typedef enum logic [1:0] {SCAN_TEXT, SCAN_LINE, SCAN_BLOCK} scan_mode_t;

  typedef struct packed {
    logic [BYTE_W-1:0]     ch;
    logic                  ch_valid;
    logic                  eos_mark;
    logic                  unclosed;
    logic [LINE_NUM_W-1:0] line;
    logic                  last;
  } clean_word_t;

  scan_mode_t               scan;
  logic [NEST_BITS_DEF-1:0] depth;
  logic                     slash_seen;
  logic                     star_seen;
  logic                     space_sent;
  logic [LINE_BITS_DEF-1:0] line_cnt;
  clean_word_t              step_words[$];
  clean_word_t              cleaned_q[$];
  int                       fail_count = 0;
  int                       queued = 0;

  assign errors  = fail_count;
  assign pending = queued;

  function automatic void clear_scan();
    scan       = SCAN_TEXT;
    depth      = '0;
    slash_seen = 1'b0;
    star_seen  = 1'b0;
    space_sent = 1'b0;
    line_cnt   = LINE_BITS_DEF'(1);
  endfunction

  function automatic void bump_line();
    if (line_cnt != '1) line_cnt = line_cnt + 1'b1;
  endfunction

  function automatic void push_clean(input logic [BYTE_W-1:0] ch, input logic v,
                                     input logic e, input logic u);
    clean_word_t w;
    w          = '0;
    w.ch       = ch;
    w.ch_valid = v;
    w.eos_mark = e;
    w.unclosed = u;
    step_words.push_back(w);
  endfunction

  // one space per run of whitespace or comments
  function automatic void push_space();
    if (!space_sent) begin
      push_clean(CH_SPACE, 1'b1, 1'b0, 1'b0);
      space_sent = 1'b1;
    end
  endfunction

  function automatic void text_char(input logic [BYTE_W-1:0] b);
    case (b)
      CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_CR: begin
        if (b == CH_LF) bump_line();
        push_space();
      end
      CH_SLASH: slash_seen = 1'b1;
      default: begin
        push_clean(b, 1'b1, 1'b0, 1'b0);
        space_sent = 1'b0;
      end
    endcase
  endfunction

  function automatic void predict_word(input logic [BYTE_W-1:0] b, input logic eos);
    logic closed;
    closed = 1'b0;
    step_words.delete();
    if (eos) begin
      if (scan == SCAN_TEXT && slash_seen) push_clean(CH_SLASH, 1'b1, 1'b0, 1'b0);
      push_clean('0, 1'b0, 1'b1, scan == SCAN_BLOCK);
    end else begin
      case (scan)
        SCAN_LINE: begin
          if (b == CH_LF) begin
            bump_line();
            scan = SCAN_TEXT;
          end
        end
        SCAN_BLOCK: begin
          if (b == CH_LF) bump_line();
          if (slash_seen && b == CH_STAR) begin
            // saturate: levels past the ceiling are lost
            if (depth != '1) depth = depth + 1'b1;
          end else if (star_seen && b == CH_SLASH) begin
            if (depth != 0) depth = depth - 1'b1;
            closed = (depth == 0);
          end
          if (closed) begin
            scan       = SCAN_TEXT;
            slash_seen = 1'b0;
            star_seen  = 1'b0;
          end else begin
            slash_seen = (b == CH_SLASH);
            star_seen  = (b == CH_STAR);
          end
        end
        default: begin
          if (slash_seen) begin
            slash_seen = 1'b0;
            if (b == CH_SLASH) begin
              scan = SCAN_LINE;
              push_space();
            end else if (b == CH_STAR) begin
              // the opening star never counts toward a close
              scan      = SCAN_BLOCK;
              depth     = NEST_BITS_DEF'(1);
              star_seen = 1'b0;
              push_space();
            end else begin
              push_clean(CH_SLASH, 1'b1, 1'b0, 1'b0);
              space_sent = 1'b0;
              text_char(b);
            end
          end else begin
            text_char(b);
          end
        end
      endcase
    end
    foreach (step_words[k]) begin
      step_words[k].line = line_cnt;
      step_words[k].last = (k == step_words.size() - 1);
      cleaned_q.push_back(step_words[k]);
    end
    if (eos) clear_scan();
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("%0t: %s got 'h%0h, expected 'h%0h", $time, what, got, exp_val);
    fail_count++;
  endtask

  always @(posedge clk) begin
    clean_word_t want;
    if (rst) begin
      clear_scan();
      cleaned_q.delete();
    end else begin
      if (in_valid && in_ready) predict_word(in_byte, end_of_stream);
      if (out_valid && out_ready) begin
        if (cleaned_q.size() == 0) begin
          report_mismatch("word with nothing expected, out_byte", 32'(out_byte), '0);
        end else begin
          want = cleaned_q.pop_front();
          if (out_byte !== want.ch)
            report_mismatch("out_byte", 32'(out_byte), 32'(want.ch));
          if (byte_valid !== want.ch_valid)
            report_mismatch("byte_valid", 32'(byte_valid), 32'(want.ch_valid));
          if (end_marker !== want.eos_mark)
            report_mismatch("end_marker", 32'(end_marker), 32'(want.eos_mark));
          if (unclosed_error !== want.unclosed)
            report_mismatch("unclosed_error", 32'(unclosed_error), 32'(want.unclosed));
          if (line_number !== want.line)
            report_mismatch("line_number", 32'(line_number), 32'(want.line));
          if (last_of_run !== want.last)
            report_mismatch("last_of_run", 32'(last_of_run), 32'(want.last));
        end
      end
    end
    queued <= cleaned_q.size();
  end

endmodule

`default_nettype wire

// ===== sim/tb_nested_comment_stripper.sv =====
`default_nettype none

module tb_nested_comment_stripper;
  import ncs_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int PHASE_WORDS    = 225;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [BYTE_W-1:0]     in_byte = '0;
  logic                  end_of_stream = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [BYTE_W-1:0]     out_byte;
  logic                  byte_valid;
  logic                  end_marker;
  logic                  unclosed_error;
  logic [LINE_NUM_W-1:0] line_number;
  logic                  last_of_run;
  int                    errors;
  int                    pending;
  int                    stall_cycles = 0;
  int                    sender_idle_pct = 0;
  int                    receiver_stall_pct = 0;
  int                    words_sent = 0;
  int                    idle_by_phase[4]  = '{0, 78, 0, 17};
  int                    stall_by_phase[4] = '{0, 0, 78, 17};

  // {end_of_stream, in_byte}
  logic [8:0] opening_words[$] = '{
    {1'b0, 8'h00}, {1'b0, 8'hFF}, {1'b0, CH_SPACE}, {1'b0, CH_TAB},
    {1'b0, CH_LF}, {1'b0, CH_VT}, {1'b0, CH_CR},
    // lone slash, then a line comment
    {1'b0, CH_SLASH}, {1'b0, 8'h78}, {1'b0, CH_SLASH}, {1'b0, CH_SLASH}, {1'b0, CH_LF},
    // slash-star-slash stays open; nest one deeper and unwind
    {1'b0, CH_SLASH}, {1'b0, CH_STAR}, {1'b0, CH_SLASH}, {1'b0, CH_STAR},
    {1'b0, CH_STAR}, {1'b0, CH_SLASH}, {1'b0, CH_SPACE}, {1'b0, CH_STAR}, {1'b0, CH_SLASH},
    // held slash flushed at end of stream, then an unclosed block and a line comment ended by it
    {1'b0, CH_SLASH}, {1'b1, 8'hA5},
    {1'b0, CH_SLASH}, {1'b0, CH_STAR}, {1'b1, 8'h5A},
    {1'b0, CH_SLASH}, {1'b0, CH_SLASH}, {1'b1, 8'hFF}
  };

  always #2 clk = ~clk;

  nested_comment_stripper u_dut (.*);

  ncs_checker u_checker (.*);

  always @(posedge clk) out_ready <= ($urandom_range(99) >= receiver_stall_pct);

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_word(input logic [BYTE_W-1:0] b, input logic eos);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_byte       <= b;
    end_of_stream <= eos;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic end_stream();
    send_word(BYTE_W'($urandom_range(255)), 1'b1);
  endtask

  // hold off until every expected word is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [BYTE_W-1:0] white_byte();
    case ($urandom_range(4))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      3: return CH_VT;
      default: return CH_CR;
    endcase
  endfunction

  // any byte but slash or star, newline fairly often
  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] b;
    if ($urandom_range(5) == 0) return CH_LF;
    do b = BYTE_W'($urandom_range(255)); while (b == CH_SLASH || b == CH_STAR);
    return b;
  endfunction

  function automatic logic [BYTE_W-1:0] spice_byte();
    case ($urandom_range(7))
      0: return CH_SLASH;
      1: return CH_STAR;
      2: return CH_LF;
      3: return white_byte();
      default: return BYTE_W'($urandom_range(255));
    endcase
  endfunction

  // separators keep a close from fusing with the next open
  task automatic send_block_comment(input bit close_it);
    int lvl;
    int toks;
    send_word(CH_SLASH, 1'b0);
    send_word(CH_STAR, 1'b0);
    send_word(plain_byte(), 1'b0);
    lvl  = 1;
    toks = 0;
    while (lvl > 0 && (close_it || toks < 6)) begin
      toks++;
      case ($urandom_range(3))
        0: begin
          if (lvl < 4 && toks < 12) begin
            send_word(CH_SLASH, 1'b0);
            send_word(CH_STAR, 1'b0);
            lvl++;
          end
        end
        1: begin
          send_word(CH_STAR, 1'b0);
          send_word(CH_SLASH, 1'b0);
          lvl--;
        end
        default: send_word(plain_byte(), 1'b0);
      endcase
      send_word(plain_byte(), 1'b0);
    end
  endtask

  task automatic send_segment();
    case ($urandom_range(11))
      0, 1: repeat ($urandom_range(1, 6))
        send_word(BYTE_W'($urandom_range(8'h7E, 8'h21)), 1'b0);
      2: repeat ($urandom_range(1, 4)) send_word(white_byte(), 1'b0);
      3: begin
        send_word(CH_SLASH, 1'b0);
        send_word(CH_SLASH, 1'b0);
        repeat ($urandom_range(0, 5)) send_word(plain_byte(), 1'b0);
        send_word(CH_LF, 1'b0);
      end
      4, 5: send_block_comment(1'b1);
      6: begin
        send_word(CH_SLASH, 1'b0);
        send_word(spice_byte(), 1'b0);
      end
      7, 8: repeat ($urandom_range(1, 4)) send_word(spice_byte(), 1'b0);
      9: end_stream();
      10: begin
        send_block_comment(1'b0);
        end_stream();
      end
      default: begin
        if ($urandom_range(7) == 0) drain();
        else send_word(BYTE_W'($urandom_range(255)), 1'b0);
      end
    endcase
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    for (int phase = 0; phase < 4; phase++) begin
      sender_idle_pct     = idle_by_phase[phase];
      receiver_stall_pct <= stall_by_phase[phase];
      if (phase == 0) begin
        foreach (opening_words[i]) send_word(opening_words[i][7:0], opening_words[i][8]);
      end
      words_sent = 0;
      while (words_sent < PHASE_WORDS) send_segment();
      end_stream();
      drain();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/ncs_pkg.sv
rtl/nested_comment_stripper.sv
rtl/ncs_checker.sv
sim/ncs_checker.sv
sim/tb_nested_comment_stripper.sv
